/* hw/rtl/serial_step_command_generator_core_defines.svh */
// ------------------------------------------------------------------------
// Serial step command generator: assertion macros
// Shared concurrent assertion forms used by the core.
// ------------------------------------------------------------------------
`ifndef SERIAL_STEP_COMMAND_GENERATOR_CORE_DEFINES_SVH
`define SERIAL_STEP_COMMAND_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication
`define SSCG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSCG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sscg_pkg.sv */
// ------------------------------------------------------------------------
// sscg_pkg
// Types and character codes for the serial step command generator.
// ------------------------------------------------------------------------
package sscg_pkg;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_DIGITS  = 2'd1,
        PH_STOPPED = 2'd2
    } phase_t;

    typedef struct packed {
        logic        load;
        logic [31:0] value;
    } load_t;

endpackage

/* hw/rtl/sscg_line_parser.sv */
// ------------------------------------------------------------------------
// sscg_line_parser
// Incremental atoi-style line parser; issues a saturated load on CR/LF.
// ------------------------------------------------------------------------
module sscg_line_parser #(
    parameter int BUFFER_CHARS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           rx_byte,
    output sscg_pkg::load_t      load_cmd
);

    localparam int CW = $clog2(BUFFER_CHARS + 1);
    localparam logic [CW-1:0] CHAR_MAX = CW'(BUFFER_CHARS);

    logic [CW-1:0]    chars_reg, chars_next;
    sscg_pkg::phase_t phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [31:0]      mag_reg, mag_next;

    logic        is_eol, is_sign, is_digit;
    logic [34:0] mag_x10;
    logic [34:0] mag_sum;

    assign is_eol   = (rx_byte == sscg_pkg::CHAR_LF) || (rx_byte == sscg_pkg::CHAR_CR);
    assign is_sign  = (rx_byte == sscg_pkg::CHAR_MINUS) || (rx_byte == sscg_pkg::CHAR_PLUS);
    assign is_digit = (rx_byte >= sscg_pkg::CHAR_ZERO) && (rx_byte <= sscg_pkg::CHAR_NINE);

    assign mag_x10 = {mag_reg, 3'b000} + {2'b00, mag_reg, 1'b0};
    assign mag_sum = mag_x10 + {31'd0, 4'(rx_byte - sscg_pkg::CHAR_ZERO)};

    always_comb
    begin
        chars_next     = chars_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        load_cmd.load  = 1'b0;
        if (neg_reg)
        begin
            load_cmd.value = 32'd0 - mag_reg;
        end
        else if (mag_reg > sscg_pkg::POS_MAX)
        begin
            load_cmd.value = sscg_pkg::POS_MAX;
        end
        else
        begin
            load_cmd.value = mag_reg;
        end

        if (fire)
        begin
            if (is_eol)
            begin
                load_cmd.load = 1'b1;
                chars_next    = '0;
                phase_next    = sscg_pkg::PH_START;
                neg_next      = 1'b0;
                mag_next      = '0;
            end
            else if ((is_sign || is_digit) && (chars_reg < CHAR_MAX))
            begin
                chars_next = chars_reg + CW'(1);
                if (is_sign)
                begin
                    case (phase_reg)
                        sscg_pkg::PH_START:
                        begin
                            neg_next   = (rx_byte == sscg_pkg::CHAR_MINUS);
                            phase_next = sscg_pkg::PH_DIGITS;
                        end
                        default:
                        begin
                            phase_next = sscg_pkg::PH_STOPPED;
                        end
                    endcase
                end
                else
                begin
                    case (phase_reg)
                        sscg_pkg::PH_START, sscg_pkg::PH_DIGITS:
                        begin
                            if (mag_sum > {3'b000, sscg_pkg::MAG_LIMIT})
                            begin
                                mag_next = sscg_pkg::MAG_LIMIT;
                            end
                            else
                            begin
                                mag_next = mag_sum[31:0];
                            end
                            phase_next = sscg_pkg::PH_DIGITS;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_reg <= '0;
            phase_reg <= sscg_pkg::PH_START;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
        end
        else
        begin
            chars_reg <= chars_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
        end
    end

endmodule

/* hw/rtl/serial_step_command_generator_core.sv */
// ------------------------------------------------------------------------
// serial_step_command_generator_core
// Serial text to signed step count; timer ticks drive step/dir lines.
// ------------------------------------------------------------------------
//  channel | handshake               | word
//  --------+-------------------------+-------------------------------------
//  in      | in_valid / in_stall     | operation, rx_byte
//  out     | out_valid / out_stall   | step_level, dir_level, steps_left
//
//  One word per cycle sustained while out_stall is low; a word passes the
//  input register, then the result register, with the single update between them.
//  Reset clears the step count, step and dir state, parser state and both valids.
//  in_stall rises only while a word waits in the input register and the
//  result register is full and stalled.
// ------------------------------------------------------------------------
`include "serial_step_command_generator_core_defines.svh"

module serial_step_command_generator_core #(
    parameter int BUFFER_CHARS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               step_level,
    output logic               dir_level,
    output logic signed [31:0] steps_left
);

    logic        iv_reg;
    logic        op_reg;
    logic [7:0]  byte_reg;
    logic        advance;

    logic [31:0] steps_reg, steps_next;
    logic        step_reg, step_next;
    logic        dir_reg, dir_next;

    logic        ov_reg;
    logic        step_out_reg;
    logic        dir_out_reg;
    logic [31:0] steps_out_reg;

    sscg_pkg::load_t load_cmd;

    assign advance  = iv_reg && (!ov_reg || !out_stall);
    assign in_stall = iv_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            iv_reg <= 1'b1;
        end
        else if (advance)
        begin
            iv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg   <= operation;
            byte_reg <= rx_byte;
        end
    end

    sscg_line_parser #(
        .BUFFER_CHARS (BUFFER_CHARS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance && (op_reg == sscg_pkg::OP_BYTE)),
        .rx_byte  (byte_reg),
        .load_cmd (load_cmd)
    );

    always_comb
    begin
        steps_next = steps_reg;
        step_next  = step_reg;
        dir_next   = dir_reg;
        if (advance)
        begin
            if (op_reg == sscg_pkg::OP_TICK)
            begin
                if (steps_reg != 32'd0)
                begin
                    dir_next   = !steps_reg[31];
                    step_next  = !step_reg;
                    steps_next = steps_reg[31] ? (steps_reg + 32'd1) : (steps_reg - 32'd1);
                end
            end
            else if (load_cmd.load)
            begin
                steps_next = load_cmd.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= '0;
            step_reg  <= 1'b0;
            dir_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            steps_reg <= steps_next;
            step_reg  <= step_next;
            dir_reg   <= dir_next;
            if (advance)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            step_out_reg  <= step_next;
            dir_out_reg   <= dir_next;
            steps_out_reg <= steps_next;
        end
    end

    assign out_valid  = ov_reg;
    assign step_level = step_out_reg;
    assign dir_level  = dir_out_reg;
    assign steps_left = steps_out_reg;

    `SSCG_ASSERT_NOW(a_stall_from_out, clk, rst_n, in_stall, (ov_reg && out_stall),
        "input stalled without output backpressure")
    `SSCG_ASSERT_NEXT(a_tick_toggles, clk, rst_n,
        (advance && (op_reg == sscg_pkg::OP_TICK) && (steps_reg != 32'd0)),
        (step_reg != $past(step_reg)), "tick with nonzero count did not toggle step")
    `SSCG_ASSERT_NEXT(a_byte_keeps_lines, clk, rst_n,
        (advance && (op_reg == sscg_pkg::OP_BYTE)),
        ($stable(step_reg) && $stable(dir_reg)), "serial byte changed step or dir")
    `SSCG_ASSERT_NEXT(a_result_updates, clk, rst_n, advance,
        (ov_reg && (steps_out_reg == steps_reg)), "result register missed update")

endmodule

/* tb/tb.sv */
// ------------------------------------------------------------------------
// tb: serial step command generator core
// Feeds received bytes and timer ticks through the valid/stall input
// channel, predicts the step line, direction line and remaining count for
// every accepted word, and checks each result word in order. A short
// table of hand-picked words is followed by random lines, noise, ticks,
// random idling on both sides, a long output hold-off and a full drain.
// ------------------------------------------------------------------------
module tb;
    import sscg_pkg::*;

    localparam int BUF_CHARS    = 10;
    localparam int ITEM_TARGET  = 1850;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic               step;
        logic               dir;
        logic signed [31:0] count;
    } levels_t;

    typedef struct {
        op_t        op;
        logic [7:0] ch;
        bit         fixed;
        levels_t    want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               operation;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_stall;
    logic               step_level;
    logic               dir_level;
    logic signed [31:0] steps_left;

    // typed-in expectation travelling with the word
    logic               word_fixed;
    levels_t            word_want;

    logic [31:0]        pend_count;
    logic               pend_step;
    logic               pend_dir;
    logic [3:0]         chars_in;
    phase_t             line_phase;
    logic               line_neg;
    logic [31:0]        line_mag;

    levels_t            expected_levels[$];
    stim_row_t          directed[$];
    int                 errors;
    int                 words_sent;
    int                 hold_reqs;
    int                 holds_done;
    bit                 tx_quiet;
    bit                 rx_quiet;

    serial_step_command_generator_core #(
        .BUFFER_CHARS(BUF_CHARS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .step_level (step_level),
        .dir_level  (dir_level),
        .steps_left (steps_left)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    function automatic levels_t advance_stepper(input op_t op, input logic [7:0] ch);
        logic        is_sign;
        logic        is_digit;
        logic [63:0] next_mag;
        logic [31:0] mag;
        is_sign  = (ch == CHAR_MINUS) || (ch == CHAR_PLUS);
        is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        if (op == OP_TICK)
        begin
            if (pend_count != 32'd0)
            begin
                if (!pend_count[31])
                begin
                    pend_dir   = 1'b1;
                    pend_count = pend_count - 32'd1;
                end
                else
                begin
                    pend_dir   = 1'b0;
                    pend_count = pend_count + 32'd1;
                end
                pend_step = ~pend_step;
            end
        end
        else if (ch == CHAR_LF || ch == CHAR_CR)
        begin
            if (line_neg)
            begin
                mag        = (line_mag > MAG_LIMIT) ? MAG_LIMIT : line_mag;
                pend_count = -mag;
            end
            else
            begin
                mag        = (line_mag > POS_MAX) ? POS_MAX : line_mag;
                pend_count = mag;
            end
            chars_in   = 4'd0;
            line_phase = PH_START;
            line_neg   = 1'b0;
            line_mag   = 32'd0;
        end
        else if ((is_sign || is_digit) && chars_in < BUF_CHARS)
        begin
            chars_in = chars_in + 4'd1;
            if (is_sign)
            begin
                if (line_phase == PH_START)
                begin
                    line_neg   = (ch == CHAR_MINUS);
                    line_phase = PH_DIGITS;
                end
                else
                begin
                    line_phase = PH_STOPPED;
                end
            end
            else if (line_phase != PH_STOPPED)
            begin
                next_mag = {32'd0, line_mag} * 64'd10 + 64'(ch) - 64'(CHAR_ZERO);
                if (next_mag > {32'd0, MAG_LIMIT})
                    next_mag = {32'd0, MAG_LIMIT};
                line_mag   = next_mag[31:0];
                line_phase = PH_DIGITS;
            end
        end
        return '{pend_step, pend_dir, pend_count};
    endfunction

    always @(posedge clk)
    begin : in_monitor
        levels_t lv;
        if (rst_n && in_valid && !in_stall)
        begin
            lv = advance_stepper(op_t'(operation), rx_byte);
            if (word_fixed)
                lv = word_want;
            expected_levels.push_back(lv);
        end
    end

    always @(posedge clk)
    begin : out_monitor
        levels_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_levels.size() == 0)
            begin
                $display("%0t unexpected word: step %b dir %b count %0d",
                         $time, step_level, dir_level, steps_left);
                errors++;
            end
            else
            begin
                want = expected_levels.pop_front();
                if (step_level !== want.step)
                begin
                    $display("%0t step_level expected %b actual %b",
                             $time, want.step, step_level);
                    errors++;
                end
                if (dir_level !== want.dir)
                begin
                    $display("%0t dir_level expected %b actual %b",
                             $time, want.dir, dir_level);
                    errors++;
                end
                if (steps_left !== want.count)
                begin
                    $display("%0t steps_left expected %0d actual %0d",
                             $time, want.count, steps_left);
                    errors++;
                end
            end
        end
    end

    // output side: random stalls, quiet stretch, long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != holds_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                holds_done++;
            end
            else
            begin
                out_stall <= !rx_quiet && ($urandom_range(0, 99) < 15);
            end
        end
    end

    task automatic add_row(input op_t op, input logic [7:0] ch, input bit fixed = 1'b0,
                           input logic s = 1'b0, input logic d = 1'b0,
                           input logic signed [31:0] c = 32'sd0);
        stim_row_t r;
        r.op    = op;
        r.ch    = ch;
        r.fixed = fixed;
        r.want  = '{s, d, c};
        directed.push_back(r);
    endtask

    task automatic send_word(input op_t op, input logic [7:0] ch,
                             input bit fixed = 1'b0, input levels_t want = '0);
        while (!tx_quiet && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        rx_byte    <= ch;
        word_fixed <= fixed;
        word_want  <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == OP_TICK || ch == CHAR_LF || ch == CHAR_CR || ch == CHAR_PLUS
            || ch == CHAR_MINUS || (ch >= CHAR_ZERO && ch <= CHAR_NINE))
            words_sent++;
    endtask

    task automatic send_tick();
        send_word(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_digit();
        send_word(OP_BYTE, CHAR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic send_line_end();
        case ($urandom_range(0, 5))
            0:
            begin
                send_word(OP_BYTE, CHAR_CR);
                send_word(OP_BYTE, CHAR_LF);
            end
            1, 2:    send_word(OP_BYTE, CHAR_CR);
            default: send_word(OP_BYTE, CHAR_LF);
        endcase
    endtask

    task automatic send_random_unit();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            case ($urandom_range(0, 2))
                1:       send_word(OP_BYTE, CHAR_PLUS);
                2:       send_word(OP_BYTE, CHAR_MINUS);
                default: ;
            endcase
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 13) : $urandom_range(1, 2);
            repeat (n)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_word(OP_BYTE, 8'($urandom_range(8'h3A, 8'hFF)));
                send_digit();
            end
            send_line_end();
            repeat ($urandom_range(0, 40)) send_tick();
        end
        else if (kind < 85)
        begin
            repeat ($urandom_range(1, 14))
            begin
                case ($urandom_range(0, 2))
                    0:       send_word(OP_BYTE, CHAR_PLUS);
                    1:       send_word(OP_BYTE, CHAR_MINUS);
                    default: send_digit();
                endcase
            end
            send_line_end();
            repeat ($urandom_range(0, 5)) send_tick();
        end
        else if (kind < 93)
        begin
            send_word(OP_BYTE, 8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 8)) send_tick();
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_levels.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_BYTE;
        rx_byte    = 8'h00;
        word_fixed = 1'b0;
        word_want  = '0;
        pend_count = 32'd0;
        pend_step  = 1'b0;
        pend_dir   = 1'b0;
        chars_in   = 4'd0;
        line_phase = PH_START;
        line_neg   = 1'b0;
        line_mag   = 32'd0;
        errors     = 0;
        words_sent = 0;
        hold_reqs  = 0;
        holds_done = 0;
        tx_quiet   = 1'b0;
        rx_quiet   = 1'b0;

        // tick on a zero count right after reset
        add_row(OP_TICK, 8'hA5, 1'b1, 1'b0, 1'b0, 32'sd0);
        add_row(OP_BYTE, CHAR_MINUS);
        add_row(OP_BYTE, CHAR_ZERO + 8'd5);
        add_row(OP_BYTE, CHAR_CR, 1'b1, 1'b0, 1'b0, -32'sd5);
        add_row(OP_TICK, 8'h5A, 1'b1, 1'b1, 1'b0, -32'sd4);
        // empty line clears the count
        add_row(OP_BYTE, CHAR_LF, 1'b1, 1'b1, 1'b0, 32'sd0);
        // misplaced sign stops the reading, other bytes ignored
        add_row(OP_BYTE, CHAR_PLUS);
        add_row(OP_BYTE, CHAR_ZERO + 8'd1);
        add_row(OP_BYTE, CHAR_ZERO + 8'd2);
        add_row(OP_BYTE, CHAR_MINUS);
        add_row(OP_BYTE, CHAR_ZERO + 8'd3);
        add_row(OP_BYTE, 8'hFF);
        add_row(OP_BYTE, CHAR_LF, 1'b1, 1'b1, 1'b0, 32'sd12);
        // eleven nines: full buffer and positive saturation
        repeat (11) add_row(OP_BYTE, CHAR_NINE);
        add_row(OP_BYTE, CHAR_CR, 1'b1, 1'b1, 1'b0, 32'sd2147483647);
        add_row(OP_TICK, 8'h00, 1'b1, 1'b0, 1'b1, 32'sd2147483646);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_word(directed[i].op, directed[i].ch, directed[i].fixed, directed[i].want);
        wait_drained();

        while (words_sent < ITEM_TARGET)
        begin
            tx_quiet = (words_sent >= 600 && words_sent < 900);
            rx_quiet = tx_quiet;
            if (words_sent >= 1200 && hold_reqs == 0)
                hold_reqs = 1;
            send_random_unit();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/sscg_pkg.sv
hw/rtl/sscg_line_parser.sv
hw/rtl/serial_step_command_generator_core.sv
tb/tb.sv
